// File: rtl/core/stac_pkg.sv
// Shared types, constants and codes for the state timeline admission table.
package stac_pkg;

    localparam int SLOTS        = 64;
    localparam int IDX_W        = $clog2(SLOTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int REQ_W        = 11;
    localparam int MAX_RETAINED = 1024;
    localparam int TIME_W       = 63;
    localparam int ID_W         = 32;
    localparam int PADDR_W      = 4;

    localparam logic [1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [1:0] REG_MAX_STATES   = 2'd1;
    localparam logic [1:0] REG_MAX_REQUESTS = 2'd2;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_COMMIT,
        OP_FINALIZE,
        OP_QUERY
    } op_t;

    typedef enum logic [3:0] {
        ST_OK,
        ST_BAD_REQUEST,
        ST_DUPLICATE,
        ST_OUT_OF_ORDER,
        ST_FINALIZED,
        ST_REQ_CAP,
        ST_STATE_CAP,
        ST_BAD_COMMIT,
        ST_CONFLICT,
        ST_REGRESSION
    } status_t;

    typedef enum logic [1:0] {
        DISP_SHARE,
        DISP_SUPPRESS,
        DISP_NEW
    } disp_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_UPDATE,
        ACT_INSERT,
        ACT_COMPACT
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_WRITE,
        S_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] event_time;
        logic [ID_W-1:0]   request_id;
        logic              request_wellformed;
        logic [ID_W-1:0]   commit_id;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        status;
        logic [1:0]        disposition;
        logic [TIME_W-1:0] entry_time;
        logic              entry_committed;
        logic [ID_W-1:0]   entry_commit_id;
        logic [REQ_W-1:0]  count_a;
        logic [REQ_W-1:0]  count_b;
        logic              finalized_valid;
        logic [TIME_W-1:0] finalized_time;
        logic              last_valid;
        logic [ID_W-1:0]   last_request;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] etime;
        logic [REQ_W-1:0]  reqs;
        logic              committed;
        logic [ID_W-1:0]   cid;
    } entry_t;

    typedef struct packed {
        logic [31:0] min_interval;
        logic [6:0]  max_states;
        logic [10:0] max_requests;
    } cfg_t;

    typedef struct packed {
        act_t              act;
        logic [CNT_W-1:0]  pos;
        entry_t            ent;
        logic [CNT_W-1:0]  k;
        logic [CNT_W-1:0]  count;
        logic [REQ_W-1:0]  retained;
        logic              final_set;
        logic [TIME_W-1:0] final_time;
        logic              last_set;
        logic [ID_W-1:0]   last_id;
        out_item_t         out;
    } plan_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic move;
        logic write;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic move_done;
        logic out_free;
        act_t act_now;
        act_t act;
    } dp_stat_t;

endpackage

// File: rtl/core/stac_dp.sv
// Datapath: slot memory, scan accumulators, decision logic, result register.
module stac_dp import stac_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    entry_t slot_mem [SLOTS];
    entry_t rdata_reg;

    logic [1:0]        op_reg;
    logic [TIME_W-1:0] t_reg;
    logic [ID_W-1:0]   rid_reg;
    logic              wf_reg;
    logic [ID_W-1:0]   cid_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [REQ_W-1:0]  retained_reg;
    logic              final_set_reg;
    logic [TIME_W-1:0] final_time_reg;
    logic              last_set_reg;
    logic [ID_W-1:0]   last_id_reg;

    logic [CNT_W-1:0]  scan_idx_reg;
    logic              rvalid_reg;
    logic [CNT_W-1:0]  ret_idx_reg;
    logic [CNT_W-1:0]  lt_cnt_reg;
    logic [CNT_W-1:0]  le_cnt_reg;
    logic [REQ_W-1:0]  gt_reqs_reg;
    logic              eq_found_reg;
    entry_t            eq_ent_reg;
    logic              near_found_reg;
    logic [TIME_W-1:0] near_d_reg;
    logic [TIME_W-1:0] near_t_reg;
    logic              have_same_reg;
    logic              same_eq_reg;

    logic [CNT_W-1:0]  mv_rd_reg;
    logic [CNT_W-1:0]  mv_left_reg;
    logic              mv_up_reg;

    plan_t             plan_reg;
    plan_t             plan_next;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              scan_issue;
    logic              mv_issue;
    logic [TIME_W-1:0] gap;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [IDX_W-1:0]  mem_ra;
    entry_t            mem_wd;
    logic [CNT_W-1:0]  mv_wa;
    logic [CNT_W-1:0]  scap;
    logic [REQ_W-1:0]  rcap;

    assign scan_issue = cmd.scan && (scan_idx_reg < count_reg);
    assign mv_issue   = cmd.move && (mv_left_reg != '0);
    assign gap = (rdata_reg.etime >= t_reg) ? rdata_reg.etime - t_reg : t_reg - rdata_reg.etime;
    assign mv_wa = mv_up_reg ? ret_idx_reg - plan_reg.k : ret_idx_reg + CNT_W'(1);
    assign mem_we = cmd.write || (cmd.move && rvalid_reg);
    assign mem_wa = cmd.write ? plan_reg.pos[IDX_W-1:0] : mv_wa[IDX_W-1:0];
    assign mem_wd = cmd.write ? plan_reg.ent : rdata_reg;
    assign mem_ra = cmd.scan ? scan_idx_reg[IDX_W-1:0] : mv_rd_reg[IDX_W-1:0];
    assign scap = (cfg.max_states > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cfg.max_states[CNT_W-1:0];
    assign rcap = (cfg.max_requests > REQ_W'(MAX_RETAINED)) ? REQ_W'(MAX_RETAINED)
                                                            : cfg.max_requests;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= slot_mem[mem_ra];
    end

    always_comb begin
        plan_next            = '0;
        plan_next.act        = ACT_NONE;
        plan_next.pos        = lt_cnt_reg;
        plan_next.k          = le_cnt_reg;
        plan_next.count      = count_reg;
        plan_next.retained   = retained_reg;
        plan_next.final_set  = final_set_reg;
        plan_next.final_time = final_time_reg;
        plan_next.last_set   = last_set_reg;
        plan_next.last_id    = last_id_reg;
        plan_next.out.status = ST_OK;
        case (op_reg)
            OP_REQUEST: begin
                if (rid_reg == '0 || !wf_reg) begin
                    plan_next.out.status = ST_BAD_REQUEST;
                end else if (last_set_reg && rid_reg == last_id_reg) begin
                    plan_next.out.status = ST_DUPLICATE;
                end else if (last_set_reg && rid_reg < last_id_reg) begin
                    plan_next.out.status = ST_OUT_OF_ORDER;
                end else if (final_set_reg && t_reg <= final_time_reg) begin
                    plan_next.out.status = ST_FINALIZED;
                end else if (eq_found_reg) begin
                    if (retained_reg >= rcap) begin
                        plan_next.out.status = ST_REQ_CAP;
                    end else begin
                        plan_next.act      = ACT_UPDATE;
                        plan_next.ent      = eq_ent_reg;
                        plan_next.ent.reqs = eq_ent_reg.reqs + REQ_W'(1);
                        plan_next.retained = retained_reg + REQ_W'(1);
                        plan_next.last_set = 1'b1;
                        plan_next.last_id  = rid_reg;
                        plan_next.out.disposition = DISP_SHARE;
                        plan_next.out.entry_time      = plan_next.ent.etime;
                        plan_next.out.entry_committed = plan_next.ent.committed;
                        plan_next.out.entry_commit_id = plan_next.ent.cid;
                        plan_next.out.count_a         = plan_next.ent.reqs;
                    end
                end else if (near_found_reg) begin
                    plan_next.last_set = 1'b1;
                    plan_next.last_id  = rid_reg;
                    plan_next.out.disposition = DISP_SUPPRESS;
                    plan_next.out.entry_time  = near_t_reg;
                end else if (retained_reg >= rcap) begin
                    plan_next.out.status = ST_REQ_CAP;
                end else if (count_reg >= scap) begin
                    plan_next.out.status = ST_STATE_CAP;
                end else begin
                    plan_next.act           = ACT_INSERT;
                    plan_next.ent.etime     = t_reg;
                    plan_next.ent.reqs      = REQ_W'(1);
                    plan_next.ent.committed = 1'b0;
                    plan_next.ent.cid       = '0;
                    plan_next.count    = count_reg + CNT_W'(1);
                    plan_next.retained = retained_reg + REQ_W'(1);
                    plan_next.last_set = 1'b1;
                    plan_next.last_id  = rid_reg;
                    plan_next.out.disposition = DISP_NEW;
                    plan_next.out.entry_time  = t_reg;
                    plan_next.out.count_a     = REQ_W'(1);
                end
            end
            OP_COMMIT: begin
                if (cid_reg == '0) begin
                    plan_next.out.status = ST_BAD_COMMIT;
                end else if (final_set_reg && t_reg <= final_time_reg) begin
                    plan_next.out.status = ST_FINALIZED;
                end else if (eq_found_reg) begin
                    if (eq_ent_reg.committed && eq_ent_reg.cid != cid_reg) begin
                        plan_next.out.status = ST_CONFLICT;
                    end else if (!eq_ent_reg.committed && have_same_reg && !same_eq_reg) begin
                        plan_next.out.status = ST_CONFLICT;
                    end else begin
                        plan_next.act           = eq_ent_reg.committed ? ACT_NONE : ACT_UPDATE;
                        plan_next.ent           = eq_ent_reg;
                        plan_next.ent.committed = 1'b1;
                        plan_next.ent.cid       = cid_reg;
                        plan_next.out.entry_time      = eq_ent_reg.etime;
                        plan_next.out.entry_committed = 1'b1;
                        plan_next.out.entry_commit_id = cid_reg;
                        plan_next.out.count_a         = eq_ent_reg.reqs;
                    end
                end else if (have_same_reg) begin
                    plan_next.out.status = ST_CONFLICT;
                end else if (count_reg >= scap) begin
                    plan_next.out.status = ST_STATE_CAP;
                end else begin
                    plan_next.act           = ACT_INSERT;
                    plan_next.ent.etime     = t_reg;
                    plan_next.ent.reqs      = '0;
                    plan_next.ent.committed = 1'b1;
                    plan_next.ent.cid       = cid_reg;
                    plan_next.count = count_reg + CNT_W'(1);
                    plan_next.out.entry_time      = t_reg;
                    plan_next.out.entry_committed = 1'b1;
                    plan_next.out.entry_commit_id = cid_reg;
                end
            end
            OP_FINALIZE: begin
                if (final_set_reg && t_reg < final_time_reg) begin
                    plan_next.out.status = ST_REGRESSION;
                end else begin
                    plan_next.act = (le_cnt_reg != '0) ? ACT_COMPACT : ACT_NONE;
                    plan_next.out.entry_time = final_set_reg ? final_time_reg : '0;
                    plan_next.out.count_a    = REQ_W'(le_cnt_reg);
                    plan_next.out.count_b    = (retained_reg >= gt_reqs_reg)
                                               ? retained_reg - gt_reqs_reg : '0;
                    plan_next.count      = count_reg - le_cnt_reg;
                    plan_next.retained   = gt_reqs_reg;
                    plan_next.final_set  = 1'b1;
                    plan_next.final_time = t_reg;
                end
            end
            default: begin
                plan_next.out.count_a = REQ_W'(count_reg);
                plan_next.out.count_b = retained_reg;
            end
        endcase
        plan_next.out.finalized_valid = plan_next.final_set;
        plan_next.out.finalized_time  = plan_next.final_time;
        plan_next.out.last_valid      = plan_next.last_set;
        plan_next.out.last_request    = plan_next.last_id;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_data.opcode;
            t_reg   <= s_data.event_time;
            rid_reg <= s_data.request_id;
            wf_reg  <= s_data.request_wellformed;
            cid_reg <= s_data.commit_id;
            lt_cnt_reg     <= '0;
            le_cnt_reg     <= '0;
            gt_reqs_reg    <= '0;
            eq_found_reg   <= 1'b0;
            near_found_reg <= 1'b0;
            have_same_reg  <= 1'b0;
        end else if (cmd.scan && rvalid_reg) begin
            if (rdata_reg.etime < t_reg) begin
                lt_cnt_reg <= lt_cnt_reg + CNT_W'(1);
            end
            if (rdata_reg.etime <= t_reg) begin
                le_cnt_reg <= le_cnt_reg + CNT_W'(1);
            end else begin
                gt_reqs_reg <= gt_reqs_reg + rdata_reg.reqs;
            end
            if (rdata_reg.etime == t_reg) begin
                eq_found_reg <= 1'b1;
                eq_ent_reg   <= rdata_reg;
            end
            if (gap < TIME_W'(cfg.min_interval) && (!near_found_reg || gap < near_d_reg)) begin
                near_found_reg <= 1'b1;
                near_d_reg     <= gap;
                near_t_reg     <= rdata_reg.etime;
            end
            if (!have_same_reg && rdata_reg.committed && rdata_reg.cid == cid_reg) begin
                have_same_reg <= 1'b1;
                same_eq_reg   <= (rdata_reg.etime == t_reg);
            end
        end
        if (cmd.decide) begin
            plan_reg <= plan_next;
        end
        ret_idx_reg <= cmd.scan ? scan_idx_reg : mv_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            retained_reg   <= '0;
            final_set_reg  <= 1'b0;
            final_time_reg <= '0;
            last_set_reg   <= 1'b0;
            last_id_reg    <= '0;
            scan_idx_reg   <= '0;
            rvalid_reg     <= 1'b0;
            mv_left_reg    <= '0;
            mv_rd_reg      <= '0;
            mv_up_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            rvalid_reg <= scan_issue || mv_issue;
            if (cmd.load) begin
                scan_idx_reg <= '0;
            end else if (scan_issue) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            if (cmd.decide) begin
                case (plan_next.act)
                    ACT_INSERT: begin
                        mv_rd_reg   <= count_reg - CNT_W'(1);
                        mv_left_reg <= count_reg - lt_cnt_reg;
                        mv_up_reg   <= 1'b0;
                    end
                    ACT_COMPACT: begin
                        mv_rd_reg   <= le_cnt_reg;
                        mv_left_reg <= count_reg - le_cnt_reg;
                        mv_up_reg   <= 1'b1;
                    end
                    default: begin
                        mv_left_reg <= '0;
                    end
                endcase
            end else if (mv_issue) begin
                mv_left_reg <= mv_left_reg - CNT_W'(1);
                mv_rd_reg   <= mv_up_reg ? mv_rd_reg + CNT_W'(1) : mv_rd_reg - CNT_W'(1);
            end
            if (cmd.finish) begin
                count_reg      <= plan_reg.count;
                retained_reg   <= plan_reg.retained;
                final_set_reg  <= plan_reg.final_set;
                final_time_reg <= plan_reg.final_time;
                last_set_reg   <= plan_reg.last_set;
                last_id_reg    <= plan_reg.last_id;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= plan_reg.out;
        end
    end

    assign stat.scan_done = !scan_issue && !rvalid_reg;
    assign stat.move_done = (mv_left_reg == '0) && !rvalid_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.act_now   = plan_next.act;
    assign stat.act       = plan_reg.act;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/stac_ctrl.sv
// Controller: sequences scan, decision, entry moves, write-back and result.
module stac_ctrl import stac_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (stat.scan_done) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                case (stat.act_now)
                    ACT_INSERT, ACT_COMPACT: state_next = S_MOVE;
                    ACT_UPDATE:              state_next = S_WRITE;
                    default:                 state_next = S_FINISH;
                endcase
            end
            S_MOVE: begin
                if (stat.move_done) begin
                    state_next = (stat.act == ACT_INSERT) ? S_WRITE : S_FINISH;
                end
            end
            S_WRITE: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_SCAN:   cmd.scan   = 1'b1;
            S_DECIDE: cmd.decide = 1'b1;
            S_MOVE:   cmd.move   = 1'b1;
            S_WRITE:  cmd.write  = 1'b1;
            S_FINISH: cmd.finish = stat.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/state_timeline_admission_table_core.sv
// State timeline admission table: one transaction in, one result out, per operation.
// Operations run one at a time. Each transaction reads every retained entry of the
// slot memory once, then decides. A sorted insert or a finalize compaction then moves
// the affected entries one per cycle, and an update or insert writes one entry.
// The result register lets the next transaction start while a result is pending.
module state_timeline_admission_table_core import stac_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_interval <= '0;
            cfg_reg.max_states   <= 7'd64;
            cfg_reg.max_requests <= 11'd1024;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_MIN_INTERVAL: cfg_reg.min_interval <= pwdata;
                REG_MAX_STATES:   cfg_reg.max_states   <= pwdata[6:0];
                REG_MAX_REQUESTS: cfg_reg.max_requests <= pwdata[10:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MIN_INTERVAL: prdata = cfg_reg.min_interval;
            REG_MAX_STATES:   prdata = {25'd0, cfg_reg.max_states};
            REG_MAX_REQUESTS: prdata = {21'd0, cfg_reg.max_requests};
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    stac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    stac_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/core/stac_checker.sv
// Port-level checker for the state timeline admission table, bound to the top level.
module stac_checker import stac_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input in_item_t           s_data,
    input logic               m_valid,
    input logic               m_ready,
    input out_item_t          m_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= 4'd9)
        else $error("status code out of range");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
            m_data.count_a == '0 && m_data.count_b == '0 && m_data.entry_time == '0)
        else $error("error result carries entry data");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> pready)
        else $error("config port stalled");

endmodule

bind state_timeline_admission_table_core stac_checker u_stac_checker (.*);

// File: bench/state_timeline_admission_table_checker.sv
// Checker for the state timeline admission table: predicts each result and compares it.
module state_timeline_admission_table_checker import stac_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_item_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_item_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    logic [31:0]       cfg_interval;
    logic [6:0]        cfg_states;
    logic [10:0]       cfg_reqs;

    logic [TIME_W-1:0] tl_time [SLOTS];
    int                tl_reqs [SLOTS];
    logic              tl_com  [SLOTS];
    logic [ID_W-1:0]   tl_cid  [SLOTS];
    int                tl_n;
    int                kept;
    logic              fin_set;
    logic [TIME_W-1:0] fin_time;
    logic              last_set;
    logic [ID_W-1:0]   last_id;

    out_item_t         expected_results [$];

    function automatic void show_entry(ref out_item_t o, input int p);
        o.entry_time      = tl_time[p];
        o.entry_committed = tl_com[p];
        o.entry_commit_id = tl_cid[p];
        o.count_a         = REQ_W'(tl_reqs[p]);
    endfunction

    function automatic void insert_entry(input int p, input logic [TIME_W-1:0] t, input int r,
                                         input logic c, input logic [ID_W-1:0] id);
        int i;
        for (i = tl_n; i > p; i--) begin
            tl_time[i] = tl_time[i-1];
            tl_reqs[i] = tl_reqs[i-1];
            tl_com[i]  = tl_com[i-1];
            tl_cid[i]  = tl_cid[i-1];
        end
        tl_time[p] = t;
        tl_reqs[p] = r;
        tl_com[p]  = c;
        tl_cid[p]  = id;
        tl_n++;
    endfunction

    function automatic out_item_t admit(input in_item_t it);
        out_item_t         o;
        status_t           st;
        logic [TIME_W-1:0] t, d, best_d, best_t;
        logic              found;
        int                pos, i, scap, rcap, same, w, tot, sb, rb;
        o = '0;
        st = ST_OK;
        t = it.event_time;
        scap = (cfg_states < SLOTS) ? cfg_states : SLOTS;
        rcap = (cfg_reqs < MAX_RETAINED) ? cfg_reqs : MAX_RETAINED;
        pos = 0;
        while (pos < tl_n && tl_time[pos] < t) pos++;
        case (op_t'(it.opcode))
            OP_REQUEST: begin
                if (it.request_id == 0 || !it.request_wellformed) st = ST_BAD_REQUEST;
                else if (last_set && it.request_id == last_id) st = ST_DUPLICATE;
                else if (last_set && it.request_id < last_id) st = ST_OUT_OF_ORDER;
                else if (fin_set && t <= fin_time) st = ST_FINALIZED;
                else if (pos < tl_n && tl_time[pos] == t) begin
                    if (kept >= rcap) st = ST_REQ_CAP;
                    else begin
                        tl_reqs[pos]++;
                        kept++;
                        last_set = 1'b1;
                        last_id = it.request_id;
                        o.disposition = DISP_SHARE;
                        show_entry(o, pos);
                    end
                end else begin
                    found = 1'b0;
                    best_d = '0;
                    best_t = '0;
                    for (i = 0; i < tl_n; i++) begin
                        d = (tl_time[i] >= t) ? tl_time[i] - t : t - tl_time[i];
                        if (d < {31'b0, cfg_interval} && (!found || d < best_d)) begin
                            found = 1'b1;
                            best_d = d;
                            best_t = tl_time[i];
                        end
                    end
                    if (found) begin
                        last_set = 1'b1;
                        last_id = it.request_id;
                        o.disposition = DISP_SUPPRESS;
                        o.entry_time = best_t;
                    end else if (kept >= rcap) st = ST_REQ_CAP;
                    else if (tl_n >= scap) st = ST_STATE_CAP;
                    else begin
                        insert_entry(pos, t, 1, 1'b0, '0);
                        kept++;
                        last_set = 1'b1;
                        last_id = it.request_id;
                        o.disposition = DISP_NEW;
                        show_entry(o, pos);
                    end
                end
            end
            OP_COMMIT: begin
                same = -1;
                for (i = tl_n - 1; i >= 0; i--)
                    if (tl_com[i] && tl_cid[i] == it.commit_id) same = i;
                if (it.commit_id == 0) st = ST_BAD_COMMIT;
                else if (fin_set && t <= fin_time) st = ST_FINALIZED;
                else if (pos < tl_n && tl_time[pos] == t) begin
                    if (tl_com[pos]) begin
                        if (tl_cid[pos] != it.commit_id) st = ST_CONFLICT;
                        else show_entry(o, pos);
                    end else if (same >= 0 && same != pos) st = ST_CONFLICT;
                    else begin
                        tl_com[pos] = 1'b1;
                        tl_cid[pos] = it.commit_id;
                        show_entry(o, pos);
                    end
                end else if (same >= 0) st = ST_CONFLICT;
                else if (tl_n >= scap) st = ST_STATE_CAP;
                else begin
                    insert_entry(pos, t, 0, 1'b1, it.commit_id);
                    show_entry(o, pos);
                end
            end
            OP_FINALIZE: begin
                if (fin_set && t < fin_time) st = ST_REGRESSION;
                else begin
                    sb = tl_n;
                    rb = kept;
                    w = 0;
                    tot = 0;
                    for (i = 0; i < tl_n; i++) begin
                        if (tl_time[i] > t) begin
                            tl_time[w] = tl_time[i];
                            tl_reqs[w] = tl_reqs[i];
                            tl_com[w]  = tl_com[i];
                            tl_cid[w]  = tl_cid[i];
                            tot += tl_reqs[i];
                            w++;
                        end
                    end
                    tl_n = w;
                    kept = tot;
                    o.entry_time = fin_set ? fin_time : '0;
                    o.count_a = REQ_W'(sb - w);
                    o.count_b = (rb >= tot) ? REQ_W'(rb - tot) : '0;
                    fin_set = 1'b1;
                    fin_time = t;
                end
            end
            default: begin
                o.count_a = REQ_W'(tl_n);
                o.count_b = REQ_W'(kept);
            end
        endcase
        if (st != ST_OK) o = '0;
        o.status = st;
        o.finalized_valid = fin_set;
        o.finalized_time = fin_time;
        o.last_valid = last_set;
        o.last_request = last_id;
        return o;
    endfunction

    function automatic int check_field(input string name, input logic [63:0] e,
                                       input logic [63:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        out_item_t e;
        int        bad;
        if (!aresetn) begin
            cfg_interval = '0;
            cfg_states = 7'd64;
            cfg_reqs = 11'd1024;
            tl_n = 0;
            kept = 0;
            fin_set = 1'b0;
            fin_time = '0;
            last_set = 1'b0;
            last_id = '0;
            expected_results.delete();
            errors = 0;
            checked = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MIN_INTERVAL: cfg_interval = pwdata;
                    REG_MAX_STATES:   cfg_states = pwdata[6:0];
                    REG_MAX_REQUESTS: cfg_reqs = pwdata[10:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expected_results = {expected_results, admit(s_data)};
            if (m_valid && m_ready) begin
                checked++;
                if (expected_results.size() == 0) begin
                    $error("result with no transaction outstanding");
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    bad = 0;
                    bad += check_field("status", e.status, m_data.status);
                    bad += check_field("disposition", e.disposition, m_data.disposition);
                    bad += check_field("entry_time", e.entry_time, m_data.entry_time);
                    bad += check_field("entry_committed", e.entry_committed,
                                       m_data.entry_committed);
                    bad += check_field("entry_commit_id", e.entry_commit_id,
                                       m_data.entry_commit_id);
                    bad += check_field("count_a", e.count_a, m_data.count_a);
                    bad += check_field("count_b", e.count_b, m_data.count_b);
                    bad += check_field("finalized_valid", e.finalized_valid,
                                       m_data.finalized_valid);
                    bad += check_field("finalized_time", e.finalized_time,
                                       m_data.finalized_time);
                    bad += check_field("last_valid", e.last_valid, m_data.last_valid);
                    bad += check_field("last_request", e.last_request, m_data.last_request);
                    if (bad != 0) errors++;
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: bench/state_timeline_admission_table_core_tb.sv
// Testbench top for the state timeline admission table: stimulus, register setup and verdict.
module state_timeline_admission_table_core_tb import stac_pkg::*;;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b1;
    out_item_t          m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int errors, pending, checked;
    int sent = 0, settings = 1, quiet = 0;
    int hold_req = 0, hold_seen = 0;
    logic idle_en = 1'b1;
    logic [TIME_W-1:0] floor_t = '0;
    logic [ID_W-1:0]   next_id = 32'd100;

    state_timeline_admission_table_core dut (.*);

    state_timeline_admission_table_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .errors, .pending, .checked
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                n = 400;
                while (n > 0) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                    n--;
                end
            end
            m_ready <= !(idle_en && $urandom_range(99) < 27);
        end
    end

    function automatic in_item_t mk(op_t op, logic [TIME_W-1:0] t, logic [ID_W-1:0] rid,
                                    logic wf, logic [ID_W-1:0] cid);
        in_item_t it;
        it.opcode = op;
        it.event_time = t;
        it.request_id = rid;
        it.request_wellformed = wf;
        it.commit_id = cid;
        return it;
    endfunction

    function automatic logic [TIME_W-1:0] rnd_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    task automatic send(input in_item_t it);
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        if (idle_en)
            while ($urandom_range(99) < 27) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_cfg(input logic [31:0] iv, input logic [6:0] ms, input logic [10:0] mr);
        drain();
        apb_write(REG_MIN_INTERVAL, iv);
        apb_write(REG_MAX_STATES, 32'(ms));
        apb_write(REG_MAX_REQUESTS, 32'(mr));
        apb_write(REG_UNUSED, $urandom);
        settings++;
    endtask

    task automatic random_item();
        int          r;
        logic [TIME_W-1:0] t;
        logic [ID_W-1:0]   rid, cid;
        logic        wf;
        r = $urandom_range(99);
        t = floor_t + $urandom_range(1, 300);
        if ($urandom_range(99) < 2) t = rnd_time();
        else if ($urandom_range(99) < 3) t = floor_t - $urandom_range(0, 3);
        if (r < 55) begin
            next_id += ($urandom_range(99) < 2) ? $urandom_range(1 << 24) : $urandom_range(1, 4);
            rid = next_id;
            wf = 1'b1;
            r = $urandom_range(99);
            if (r < 5) rid = next_id;
            else if (r < 8) rid = next_id - $urandom_range(1, 50);
            else if (r < 10) rid = '0;
            else if (r < 13) wf = 1'b0;
            if (rid == next_id && r < 5) rid = next_id;
            send(mk(OP_REQUEST, t, rid, wf, $urandom));
        end else if (r < 70) begin
            r = $urandom_range(99);
            cid = (r < 60) ? $urandom_range(1, 8) : (r < 95 ? $urandom : 32'd0);
            send(mk(OP_COMMIT, t, $urandom, 1'($urandom), cid));
        end else if (r < 82) begin
            if ($urandom_range(99) < 10 && floor_t > 5) t = floor_t - $urandom_range(1, 5);
            else t = floor_t + $urandom_range(0, 120);
            if (t > floor_t) floor_t = t;
            send(mk(OP_FINALIZE, t, $urandom, 1'($urandom), $urandom));
        end else if (r < 90) begin
            send(mk(OP_QUERY, rnd_time(), $urandom, 1'($urandom), $urandom));
        end else begin
            r = $urandom_range(1);
            send(mk(r ? OP_COMMIT : OP_REQUEST, rnd_time(), $urandom, 1'($urandom), $urandom));
        end
    endtask

    task automatic random_phase(input int count);
        repeat (count) random_item();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(mk(OP_QUERY, '0, '0, 1'b0, '0));
        send(mk(OP_REQUEST, 63'd100, 32'd0, 1'b1, '0));
        send(mk(OP_REQUEST, 63'd100, 32'd5, 1'b0, '0));
        send(mk(OP_REQUEST, 63'd100, 32'd10, 1'b1, '0));
        send(mk(OP_REQUEST, 63'd100, 32'd10, 1'b1, '0));
        send(mk(OP_REQUEST, 63'd100, 32'd9, 1'b1, '0));
        send(mk(OP_REQUEST, 63'd100, 32'd11, 1'b1, '0));
        send(mk(OP_COMMIT, 63'd100, '0, 1'b0, 32'd0));
        send(mk(OP_COMMIT, 63'd100, '0, 1'b0, 32'd77));
        send(mk(OP_COMMIT, 63'd100, '0, 1'b0, 32'd77));
        send(mk(OP_COMMIT, 63'd100, '0, 1'b0, 32'd78));
        send(mk(OP_COMMIT, 63'd200, '0, 1'b0, 32'd77));
        send(mk(OP_COMMIT, 63'd300, '0, 1'b0, 32'd80));
        send(mk(OP_COMMIT, T_MAX, '1, 1'b1, '1));
        send(mk(OP_REQUEST, 63'd0, 32'd12, 1'b1, '0));

        set_cfg(32'd60, 7'd64, 11'd1024);
        send(mk(OP_REQUEST, 63'd105, 32'd20, 1'b1, '0));
        send(mk(OP_REQUEST, 63'd50, 32'd21, 1'b1, '0));
        send(mk(OP_FINALIZE, 63'd100, '0, 1'b0, '0));
        send(mk(OP_FINALIZE, 63'd100, '0, 1'b0, '0));
        send(mk(OP_FINALIZE, 63'd50, '0, 1'b0, '0));
        send(mk(OP_REQUEST, 63'd100, 32'd30, 1'b1, '0));
        send(mk(OP_QUERY, '0, '0, 1'b0, '0));
        floor_t = 63'd100;

        set_cfg(32'd0, 7'd1, 11'd1);
        send(mk(OP_REQUEST, 63'd500, 32'd40, 1'b1, '0));
        send(mk(OP_REQUEST, 63'd500, 32'd41, 1'b1, '0));
        send(mk(OP_COMMIT, 63'd600, '0, 1'b0, 32'd90));
        next_id = 32'd100;

        set_cfg(32'd0, 7'd64, 11'd1024);
        hold_req++;
        random_phase(300);
        set_cfg(32'd7, 7'd8, 11'd40);
        idle_en = 1'b0;
        hold_req++;
        random_phase(250);
        idle_en = 1'b1;
        set_cfg(32'hFFFF_FFFF, 7'd64, 11'd1024);
        random_phase(200);
        set_cfg(32'd0, 7'd1, 11'd1);
        random_phase(200);
        set_cfg(32'd20, 7'd3, 11'd1024);
        random_phase(250);
        set_cfg(32'd3, 7'd64, 11'd2);
        random_phase(200);
        set_cfg(32'd5, 7'd64, 11'd1024);
        random_phase(300);

        send(mk(OP_REQUEST, floor_t + 1, 32'hFFFF_FFFF, 1'b1, '0));
        send(mk(OP_REQUEST, floor_t + 2, 32'hFFFF_FFFF, 1'b1, '0));
        send(mk(OP_FINALIZE, T_MAX - 1, '0, 1'b0, '0));
        send(mk(OP_REQUEST, T_MAX, 32'hFFFF_FFFF, 1'b1, '0));
        send(mk(OP_FINALIZE, T_MAX, '0, 1'b0, '0));
        send(mk(OP_FINALIZE, T_MAX - 1, '0, 1'b0, '0));
        send(mk(OP_QUERY, T_MAX, '1, 1'b1, '1));

        drain();
        $display("Run covered %0d transactions in and %0d results checked", sent, checked);
        $display("over %0d register settings, with stalls and a long receiver hold-off.",
                 settings);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
